### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define SSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is low
`define SSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ssp_pkg.sv
// shared constants, types and codes of the shortest path engine
package ssp_pkg;

    localparam int NODES      = 16;
    localparam int NODE_W     = $clog2(NODES);
    localparam int ADDR_W     = 2 * NODE_W;
    localparam int EDGE_N     = 1 << ADDR_W;
    localparam int IN_NODE_W  = 4;
    localparam int OP_W       = 2;
    localparam int WEIGHT_W   = 16;
    localparam int SPEED_W    = 10;
    localparam int DIST_W     = 24;
    localparam int MIN_W      = 32;
    localparam int SCALE_W    = 14;
    localparam int NUM_W      = DIST_W + SCALE_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [MIN_W-1:0]   MIN_MAX   = {MIN_W{1'b1}};
    // 60 minutes per hour times 256 for the fraction
    localparam logic [SCALE_W-1:0] MIN_SCALE = SCALE_W'(60 * 256);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
        logic [WEIGHT_W-1:0] w;
        logic                tmode;
        logic [SPEED_W-1:0]  speed;
        logic                in_range;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR1,
        S_ADD_WR2,
        S_Q_INIT,
        S_SCAN,
        S_RELAX,
        S_DRAIN,
        S_RESULT,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### rtl/ssp_front.sv
// input side: accepts items, drops those with no effect, queues commands
module ssp_front import ssp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [IN_NODE_W-1:0] i_node_a,
    input  logic [IN_NODE_W-1:0] i_node_b,
    input  logic [WEIGHT_W-1:0]  i_edge_weight,
    input  logic                 i_time_mode,
    input  logic [SPEED_W-1:0]   i_speed_kmh,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_take
);

    t_cmd                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;
    t_cmd                cmd;
    logic                keep;
    logic                wr_en;
    logic                rd_en;

    always_comb begin
        cmd.op       = t_op'(i_operation);
        cmd.a        = NODE_W'(i_node_a);
        cmd.b        = NODE_W'(i_node_b);
        cmd.w        = i_edge_weight;
        cmd.tmode    = i_time_mode;
        cmd.speed    = i_speed_kmh;
        cmd.in_range = (int'(i_node_a) < NODES) && (int'(i_node_b) < NODES);
        // unused code and out-of-range adds change nothing
        keep = (cmd.op == OP_CLEAR) || (cmd.op == OP_QUERY) ||
               ((cmd.op == OP_ADD) && cmd.in_range);
    end

    assign full        = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd];
    assign wr_en       = push && !full && keep;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/ssp_back.sv
// execution side: edge store, dijkstra sequencer, time divider, result register
module ssp_back import ssp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_take,
    input  logic              pop,
    output logic              empty,
    output logic [DIST_W-1:0] o_distance,
    output logic [MIN_W-1:0]  o_minutes_q8,
    output logic              o_reachable,
    output logic              o_speed_error
);

    t_state                r_state;
    t_state                n_state;
    t_cmd                  r_cmd;
    logic [WEIGHT_W-1:0]   r_wmem [EDGE_N];
    logic [WEIGHT_W-1:0]   r_rdata;
    logic [EDGE_N-1:0]     r_present;
    logic [DIST_W-1:0]     r_best [NODES];
    logic [NODES-1:0]      r_reached;
    logic [NODES-1:0]      r_settled;
    logic [NODE_W-1:0]     r_idx;
    logic [NODE_W-1:0]     r_pick;
    logic                  r_found;
    logic [DIST_W-1:0]     r_min;
    logic [DIST_W-1:0]     r_pick_dist;
    logic                  r_rd_vld;
    logic [NODE_W-1:0]     r_rd_idx;
    logic                  r_upd;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_reach;
    logic                  r_serr;
    logic [NUM_W-1:0]      r_num;
    logic [SPEED_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_res_valid;

    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic                  last;
    logic                  take_pick;
    logic                  n_found;
    logic [NODE_W-1:0]     n_pick;
    logic [DIST_W-1:0]     n_min;
    logic [DIST_W:0]       sum;
    logic [DIST_W-1:0]     cand;
    logic                  relax_upd;
    logic [SPEED_W:0]      rem_sh;
    logic                  rem_ge;
    logic                  add_upd;
    logic                  reach_now;

    assign last  = (r_idx == NODE_W'(NODES - 1));
    assign empty = !r_res_valid;

    // scan compare: pick the lowest reached, unsettled vertex
    always_comb begin
        take_pick = r_reached[r_idx] && !r_settled[r_idx] &&
                    (!r_found || (r_best[r_idx] < r_min));
        n_found   = r_found || take_pick;
        n_pick    = take_pick ? r_idx : r_pick;
        n_min     = take_pick ? r_best[r_idx] : r_min;
    end

    // relax compare for the edge read in the cycle before
    always_comb begin
        sum       = {1'b0, r_pick_dist} + (DIST_W+1)'(r_rdata);
        cand      = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        relax_upd = r_rd_vld && r_present[{r_pick, r_rd_idx}] && !r_settled[r_rd_idx] &&
                    (!r_reached[r_rd_idx] || (cand < r_best[r_rd_idx]));
    end

    assign add_upd   = !r_present[{r_cmd.a, r_cmd.b}] || (r_cmd.w < r_rdata);
    assign reach_now = r_cmd.in_range && r_reached[r_cmd.b];
    assign rem_sh    = {r_rem, r_num[NUM_W-1]};
    assign rem_ge    = (rem_sh >= (SPEED_W+1)'(r_cmd.speed));

    always_comb begin
        n_state    = r_state;
        o_cmd_take = 1'b0;
        mem_rd_en  = 1'b0;
        mem_raddr  = {r_cmd.a, r_cmd.b};
        mem_we     = 1'b0;
        mem_waddr  = {r_cmd.a, r_cmd.b};
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.op)
                        OP_ADD:   n_state = S_ADD_RD;
                        OP_QUERY: n_state = S_Q_INIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: begin
                mem_rd_en = 1'b1;
                n_state   = S_ADD_WR1;
            end
            S_ADD_WR1: begin
                mem_we  = add_upd;
                n_state = S_ADD_WR2;
            end
            S_ADD_WR2: begin
                mem_we    = r_upd;
                mem_waddr = {r_cmd.b, r_cmd.a};
                n_state   = S_IDLE;
            end
            S_Q_INIT: begin
                n_state = r_cmd.in_range ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                if (last) begin
                    n_state = n_found ? S_RELAX : S_RESULT;
                end
            end
            S_RELAX: begin
                mem_rd_en = 1'b1;
                mem_raddr = {r_pick, r_idx};
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SCAN;
            end
            S_RESULT: begin
                n_state = (reach_now && r_cmd.tmode && (r_cmd.speed != '0)) ? S_MUL : S_OUT;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_res_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wmem[mem_waddr] <= r_cmd.w;
        end
        if (mem_rd_en) begin
            r_rdata <= r_wmem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_rd_vld    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_RELAX);
            if (o_cmd_take && (i_cmd.op == OP_CLEAR)) begin
                r_present <= '0;
            end
            if (mem_we) begin
                r_present[mem_waddr] <= 1'b1;
            end
            if ((r_state == S_OUT) && !r_res_valid) begin
                r_res_valid <= 1'b1;
            end else if (pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_ADD_WR1) begin
            r_upd <= add_upd;
        end
        if (relax_upd) begin
            r_best[r_rd_idx]    <= cand;
            r_reached[r_rd_idx] <= 1'b1;
        end
        unique case (r_state)
            S_Q_INIT: begin
                // only the source starts reached
                r_reached       <= NODES'(1) << r_cmd.a;
                r_settled       <= '0;
                r_best[r_cmd.a] <= '0;
                r_idx           <= '0;
                r_found         <= 1'b0;
            end
            S_SCAN: begin
                r_found <= n_found;
                r_pick  <= n_pick;
                r_min   <= n_min;
                r_idx   <= last ? '0 : r_idx + 1'b1;
                if (last && n_found) begin
                    r_settled[n_pick] <= 1'b1;
                    r_pick_dist       <= n_min;
                end
            end
            S_RELAX: begin
                r_rd_idx <= r_idx;
                r_idx    <= last ? '0 : r_idx + 1'b1;
            end
            S_DRAIN: begin
                r_found <= 1'b0;
                r_idx   <= '0;
            end
            S_RESULT: begin
                r_reach <= reach_now;
                r_dist  <= reach_now ? r_best[r_cmd.b] : '0;
                r_serr  <= r_cmd.tmode && (r_cmd.speed == '0);
                r_num   <= '0;
            end
            S_MUL: begin
                r_num <= NUM_W'(r_dist) * NUM_W'(MIN_SCALE);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                // one quotient bit a cycle, quotient shifts into r_num
                r_rem <= rem_ge ? SPEED_W'(rem_sh - (SPEED_W+1)'(r_cmd.speed))
                                : rem_sh[SPEED_W-1:0];
                r_num <= {r_num[NUM_W-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_OUT: begin
                if (!r_res_valid) begin
                    o_distance    <= r_dist;
                    o_minutes_q8  <= (r_num[NUM_W-1:MIN_W] != '0) ? MIN_MAX
                                                                  : r_num[MIN_W-1:0];
                    o_reachable   <= r_reach;
                    o_speed_error <= r_serr;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/single_source_shortest_path.sv
// top level of the shortest path engine: command queue and execution side
//
// channel   direction  handshake        payload
// input     in         push / full      operation, node_a, node_b, edge_weight, time_mode,
//                                       speed_kmh
// result    out        empty / pop      distance, minutes_q8, reachable, speed_error
//
// clear is done as it is taken; add runs through S_ADD_RD, S_ADD_WR1 and S_ADD_WR2 in the
// execution side; in a query each settled vertex costs one scan of all vertices, one pass
// over its row of the edge memory and a drain state; time mode adds the multiply and the
// bit-serial divider
// reset is synchronous and empties the graph, the command queue and the result register
// the input side keeps taking items into a 4-entry queue while a result waits to be popped
module single_source_shortest_path import ssp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [IN_NODE_W-1:0] i_node_a,
    input  logic [IN_NODE_W-1:0] i_node_b,
    input  logic [WEIGHT_W-1:0]  i_edge_weight,
    input  logic                 i_time_mode,
    input  logic [SPEED_W-1:0]   i_speed_kmh,
    output logic                 empty,
    input  logic                 pop,
    output logic [DIST_W-1:0]    o_distance,
    output logic [MIN_W-1:0]     o_minutes_q8,
    output logic                 o_reachable,
    output logic                 o_speed_error
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    ssp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_operation   (i_operation),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_edge_weight (i_edge_weight),
        .i_time_mode   (i_time_mode),
        .i_speed_kmh   (i_speed_kmh),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_take    (cmd_take)
    );

    ssp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_take    (cmd_take),
        .pop           (pop),
        .empty         (empty),
        .o_distance    (o_distance),
        .o_minutes_q8  (o_minutes_q8),
        .o_reachable   (o_reachable),
        .o_speed_error (o_speed_error)
    );

endmodule

### rtl/ssp_checker.sv
// port-level checks of the shortest path engine and their bind
`include "assert_macros.svh"

module ssp_checker import ssp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input logic [DIST_W-1:0] o_distance,
    input logic [MIN_W-1:0]  o_minutes_q8,
    input logic              o_reachable,
    input logic              o_speed_error
);

    // a waiting result holds until its transfer
    `SSP_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_distance) && $stable(o_minutes_q8))
    // unreachable results carry no distance and no time
    `SSP_ASSERT_IMP(a_unreach, i_clk, i_rst_n, !empty && !o_reachable, o_distance == '0 && o_minutes_q8 == '0)
    // zero speed gives no travel time
    `SSP_ASSERT_IMP(a_speed, i_clk, i_rst_n, !empty && o_speed_error, o_minutes_q8 == '0)
    // zero distance gives zero time
    `SSP_ASSERT_IMP(a_zero, i_clk, i_rst_n, !empty && o_distance == '0, o_minutes_q8 == '0)

endmodule

bind single_source_shortest_path ssp_checker u_ssp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_distance    (o_distance),
    .o_minutes_q8  (o_minutes_q8),
    .o_reachable   (o_reachable),
    .o_speed_error (o_speed_error)
);
